// ----- src/jet_pkg.sv -----
package jet_pkg;

   // fixed point format of every complex component: signed Q4.28
   localparam int FRAC_BITS = 28;

   localparam int DEF_WIDTH    = 1024;
   localparam int DEF_HEIGHT   = 1024;
   localparam int DEF_ITER_CAP = 1023;

   // start point queue between the mapper and the iteration unit
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register indexes on the csr port
   localparam logic [2:0] CSR_C_REAL      = 3'd0;
   localparam logic [2:0] CSR_C_IMAG      = 3'd1;
   localparam logic [2:0] CSR_MAX_ITER    = 3'd2;
   localparam logic [2:0] CSR_STEP_REAL   = 3'd3;
   localparam logic [2:0] CSR_STEP_IMAG   = 3'd4;
   localparam logic [2:0] CSR_OFFSET_REAL = 3'd5;
   localparam logic [2:0] CSR_OFFSET_IMAG = 3'd6;

   localparam logic signed [47:0] SAT_HI = 48'sd2147483647;
   localparam logic signed [47:0] SAT_LO = -48'sd2147483648;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } jet_point_type;

   // settings the iteration unit needs
   typedef struct packed {
      jet_point_type c;
      logic [9:0]    limit;
   } jet_iter_cfg_type;

   // settings the pixel mapper needs
   typedef struct packed {
      logic [30:0]        step_re;
      logic [30:0]        step_im;
      logic signed [31:0] off_re;
      logic signed [31:0] off_im;
   } jet_map_cfg_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[31:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- src/jet_front.sv -----
module jet_front
   import jet_pkg::*;
#(
   parameter int WIDTH  = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [9:0]      pixel_x,
   input  logic [9:0]      pixel_y,
   input  jet_map_cfg_type cfg,
   output logic            out_valid,
   input  logic            out_ready,
   output jet_point_type   out_point
);

   localparam logic signed [12:0] HALF_W = 13'(WIDTH / 2);
   localparam logic signed [12:0] HALF_H = 13'(HEIGHT / 2);

   logic               valid_ff, valid_in;
   jet_point_type      point_ff, point_in;
   logic signed [12:0] dx, dy;
   logic signed [47:0] start_re, start_im;
   logic               take;

   // center the pixel, scale by the per-axis step, then pan
   assign dx = $signed({3'b000, pixel_x}) - HALF_W;
   assign dy = $signed({3'b000, pixel_y}) - HALF_H;
   assign start_re = 48'(dx) * 48'($signed({1'b0, cfg.step_re})) + 48'(cfg.off_re);
   assign start_im = 48'(dy) * 48'($signed({1'b0, cfg.step_im})) + 48'(cfg.off_im);

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      point_in = point_ff;
      if (take) begin
         valid_in    = 1'b1;
         point_in.re = sat32(start_re);
         point_in.im = sat32(start_im);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      point_ff <= point_in;
   end

   assign out_valid = valid_ff;
   assign out_point = point_ff;

endmodule

// ----- src/jet_queue.sv -----
module jet_queue
   import jet_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  jet_point_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output jet_point_type pop_data
);

   localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   jet_point_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                    push, pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/jet_core.sv -----
module jet_core
   import jet_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  jet_point_type    in_point,
   input  jet_iter_cfg_type cfg,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [9:0]       rsp_count,
   output logic             rsp_escaped
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   // 4.0 in Q8.56
   localparam logic [64:0] ESC_LIMIT = 65'd4 << (2 * FRAC_BITS);

   logic [1:0]         state_ff, state_in;
   logic signed [31:0] zr_ff, zr_in, zi_ff, zi_in;
   logic [9:0]         k_ff, k_in;
   logic signed [63:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_escaped_ff, rsp_escaped_in;

   logic               slot_free, over, at_limit, finish;
   logic [64:0]        mag;
   logic signed [63:0] diff;
   logic signed [47:0] nr_wide, ni_wide;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // squares of z_k double as the escape test of iteration k; z_0 is never tested
   assign mag      = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign over     = (k_ff != '0) && (mag > ESC_LIMIT);
   assign at_limit = (k_ff == cfg.limit);
   assign finish   = over || at_limit;

   assign diff    = rr_ff - ii_ff;
   assign nr_wide = 48'(diff >>> FRAC_BITS) + 48'(cfg.c.re);
   assign ni_wide = 48'(ri_ff >>> (FRAC_BITS - 1)) + 48'(cfg.c.im);

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      zr_in          = zr_ff;
      zi_in          = zi_ff;
      k_in           = k_ff;
      rr_in          = rr_ff;
      ii_in          = ii_ff;
      ri_in          = ri_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;
      rsp_escaped_in = rsp_escaped_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               zr_in    = in_point.re;
               zi_in    = in_point.im;
               k_in     = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rr_in    = zr_ff * zr_ff;
            ii_in    = zi_ff * zi_ff;
            ri_in    = zr_ff * zi_ff;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (finish) begin
               // hold here until the result register frees up
               if (slot_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_escaped_in = over;
                  rsp_count_in   = over ? k_ff - 1'b1 : k_ff;
                  state_in       = S_IDLE;
               end
            end else begin
               zr_in    = sat32(nr_wide);
               zi_in    = sat32(ni_wide);
               k_in     = k_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zr_ff          <= zr_in;
      zi_ff          <= zi_in;
      k_ff           <= k_in;
      rr_ff          <= rr_in;
      ii_ff          <= ii_in;
      ri_ff          <= ri_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_escaped_ff <= rsp_escaped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_escaped = rsp_escaped_ff;

   a_mul_then_upd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |=> state_ff == S_UPD)
      else $error("multiply cycle not followed by update");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> state_ff == S_MUL && k_ff == '0)
      else $error("new start point not loaded with zero iterations");

   a_escape_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD && over && slot_free |=> rsp_valid_ff && rsp_escaped_ff)
      else $error("escape not reported");

   a_hold_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD && finish && !slot_free |=> state_ff == S_UPD && $stable(k_ff))
      else $error("finished pixel lost while result slot busy");

endmodule

// ----- src/julia_escape_time.sv -----
// Julia set escape-time engine. Each req word carries a pixel column and row; the
// pixel is centered, scaled by the step registers and panned by the offset registers
// into a Q4.28 start point z0, then z <- z^2 + c is iterated with c from the csr
// registers. The rsp word reports the iteration index at which |z|^2 first exceeded 4
// (escaped = 1), or the iteration limit min(max_iter, ITER_CAP) with escaped = 0.
// The start point itself is never tested. Each iteration passes through the
// iteration unit's multiply state, which forms the three 32x32 products, and then
// its update state, which adds c, saturates and tests the squares. The mapper and a
// two-entry start point queue accept new pixels while they have room, also while the
// iteration unit is busy and while a finished result waits on rsp. Write the csr
// registers only while no pixel is in flight.
module julia_escape_time
   import jet_pkg::*;
#(
   parameter int WIDTH    = DEF_WIDTH,
   parameter int HEIGHT   = DEF_HEIGHT,
   parameter int ITER_CAP = DEF_ITER_CAP
) (
   input  logic        clock,
   input  logic        reset,
   // pixel channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] escape_count, [15:10] zero
   output logic        rsp_tuser,   // [0] escaped
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [16:0] CAP = 17'(ITER_CAP);

   logic signed [31:0] c_real_ff, c_imag_ff, offset_real_ff, offset_imag_ff;
   logic [30:0]        step_real_ff, step_imag_ff;
   logic [9:0]         max_iter_ff;
   logic               csr_write;

   jet_map_cfg_type    map_cfg;
   jet_iter_cfg_type   iter_cfg;
   logic               map_valid, map_ready;
   jet_point_type      map_point;
   logic               queue_valid, queue_ready;
   jet_point_type      queue_point;
   logic [9:0]         escape_count;

   // register file: always ready, unknown indexes drop the word
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff      <= '0;
         c_imag_ff      <= '0;
         max_iter_ff    <= 10'd256;
         step_real_ff   <= 31'd262144;
         step_imag_ff   <= 31'd262144;
         offset_real_ff <= '0;
         offset_imag_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_C_REAL:      c_real_ff      <= csr_data;
            CSR_C_IMAG:      c_imag_ff      <= csr_data;
            CSR_MAX_ITER:    max_iter_ff    <= csr_data[9:0];
            CSR_STEP_REAL:   step_real_ff   <= csr_data[30:0];
            CSR_STEP_IMAG:   step_imag_ff   <= csr_data[30:0];
            CSR_OFFSET_REAL: offset_real_ff <= csr_data;
            CSR_OFFSET_IMAG: offset_imag_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign map_cfg.step_re = step_real_ff;
   assign map_cfg.step_im = step_imag_ff;
   assign map_cfg.off_re  = offset_real_ff;
   assign map_cfg.off_im  = offset_imag_ff;

   // effective limit: clamp max_iter to the build-time cap
   assign iter_cfg.c.re  = c_real_ff;
   assign iter_cfg.c.im  = c_imag_ff;
   assign iter_cfg.limit = ({7'd0, max_iter_ff} > CAP) ? CAP[9:0] : max_iter_ff;

   // front: map pixel to start point
   jet_front #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pixel_x   (req_tdata[9:0]),
      .pixel_y   (req_tdata[19:10]),
      .cfg       (map_cfg),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .out_point (map_point)
   );

   // decouple the mapper from the iteration unit
   jet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (map_valid),
      .push_ready (map_ready),
      .push_data  (map_point),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_point)
   );

   // back: iterate and hold the result word
   jet_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_ready    (queue_ready),
      .in_point    (queue_point),
      .cfg         (iter_cfg),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_count   (escape_count),
      .rsp_escaped (rsp_tuser)
   );

   assign rsp_tdata = {6'd0, escape_count};

endmodule

// ----- dv/tb_julia_escape_time.sv -----
module tb_julia_escape_time;
   import jet_pkg::*;

   // unused register index; a write there must leave every setting alone
   localparam logic [2:0] CSR_SPARE = 3'd7;

   // |z|^2 escape bound, 4.0 in Q8.56
   localparam logic [63:0] ESCAPE_SQ = 64'd4 << (2 * FRAC_BITS);
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   // 1.0 in Q4.28
   localparam int unsigned Q_ONE = 32'd1 << FRAC_BITS;

   // cycles without any handshake before the run is declared hung; this is ample
   // even for one pixel at the full iteration cap
   localparam int WATCHDOG_CYCLES = 20000;
   // length of the deliberate result-side hold-off
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 14;
   localparam int PIXELS_PER_PHASE = 60;

   // Scoreboard: holds a shadow copy of the register file, predicts each
   // pixel's escape word on acceptance and compares in order on the result side.
   class escape_scoreboard;
      typedef struct {
         logic [9:0] count;
         logic       escaped;
         logic [9:0] px;
         logic [9:0] py;
      } escape_word_type;

      escape_word_type escape_q[$];

      logic signed [31:0] c_re, c_im, off_re, off_im;
      logic [9:0]         iter_max;
      logic [30:0]        step_re, step_im;

      int errors, pixels, results, escapes, settings;

      function new();
         c_re     = '0;
         c_im     = '0;
         iter_max = 10'd256;
         step_re  = 31'd262144;
         step_im  = 31'd262144;
         off_re   = '0;
         off_im   = '0;
      endfunction

      function longint clamp32(longint v);
         if (v > Q_MAX) return Q_MAX;
         if (v < Q_MIN) return Q_MIN;
         return v;
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [31:0] data);
         case (idx)
            CSR_C_REAL:      c_re = data;
            CSR_C_IMAG:      c_im = data;
            CSR_MAX_ITER:    iter_max = data[9:0];
            CSR_STEP_REAL:   step_re = data[30:0];
            CSR_STEP_IMAG:   step_im = data[30:0];
            CSR_OFFSET_REAL: off_re = data;
            CSR_OFFSET_IMAG: off_im = data;
            default: ;
         endcase
      endfunction

      // map the pixel to z0, then iterate z <- z^2 + c until |z|^2 > 4 or the limit is reached
      function void note_pixel(input logic [9:0] px, input logic [9:0] py);
         longint pxl, pyl, srl, sil, zr, zi, nr, ni;
         logic [63:0] ar, ai;
         int lim;
         escape_word_type w;
         pxl = px;
         pyl = py;
         srl = step_re;
         sil = step_im;
         zr = clamp32((pxl - DEF_WIDTH / 2) * srl + off_re);
         zi = clamp32((pyl - DEF_HEIGHT / 2) * sil + off_im);
         lim = (iter_max > DEF_ITER_CAP) ? DEF_ITER_CAP : iter_max;
         w.count = lim[9:0];
         w.escaped = 1'b0;
         w.px = px;
         w.py = py;
         for (int it = 0; it < lim; it++) begin
            // >>> on a signed value floors, as the hardware rescale does
            nr = clamp32(((zr * zr - zi * zi) >>> FRAC_BITS) + c_re);
            ni = clamp32(((zr * zi) >>> (FRAC_BITS - 1)) + c_im);
            ar = (nr < 0) ? -nr : nr;
            ai = (ni < 0) ? -ni : ni;
            if (ar * ar + ai * ai > ESCAPE_SQ) begin
               w.count = it[9:0];
               w.escaped = 1'b1;
               break;
            end
            zr = nr;
            zi = ni;
         end
         escape_q.insert(escape_q.size(), w);
         pixels++;
      endfunction

      function void check_escape(input logic [9:0] count, input logic esc);
         escape_word_type w;
         results++;
         if (escape_q.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing pending: count %0d escaped %0b",
                     $time, count, esc);
            return;
         end
         w = escape_q.pop_front();
         if (w.escaped) escapes++;
         if (count !== w.count) begin
            errors++;
            $display("%0t: pixel (%0d,%0d) escape_count expected %0d actual %0d",
                     $time, w.px, w.py, w.count, count);
         end
         if (esc !== w.escaped) begin
            errors++;
            $display("%0t: pixel (%0d,%0d) escaped expected %0b actual %0b",
                     $time, w.px, w.py, w.escaped, esc);
         end
      endfunction

      function int pending();
         return escape_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // per-word idle draws on each side; zero gives a gapless stretch
   int unsigned req_gap_max = 5;
   int unsigned rsp_stall_max = 5;
   // set by the stimulus to request one long result-side hold-off
   bit hold_armed = 1'b0;
   int holds_done = 0;
   int idle_cycles = 0;

   escape_scoreboard sb;

   julia_escape_time dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any accepted word on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Result side: draw a stall before each word, then hold tready high until
   // a word is taken. An armed hold-off replaces one draw with a long stretch.
   initial begin
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (hold_armed) begin
            hold_armed = 1'b0;
            stall = HOLD_CYCLES;
            holds_done++;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_escape(rsp_tdata[9:0], rsp_tuser);
      end
   end

   // Offer one pixel word. Leaves tvalid high on return so that a following
   // zero-gap word goes out back to back; drop it only when a gap is drawn.
   task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pixel(px, py);
   endtask

   // Drop the pixel side and hold until every predicted word has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_valid after its last write.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Load a full view. Always start with a write to the spare index, which
   // must not disturb anything.
   task automatic apply_view(input logic [31:0] cr, input logic [31:0] ci,
                             input logic [31:0] iter, input logic [31:0] sr,
                             input logic [31:0] si, input logic [31:0] ore,
                             input logic [31:0] oim);
      write_csr(CSR_SPARE, $urandom);
      write_csr(CSR_C_REAL, cr);
      write_csr(CSR_C_IMAG, ci);
      write_csr(CSR_MAX_ITER, iter);
      write_csr(CSR_STEP_REAL, sr);
      write_csr(CSR_STEP_IMAG, si);
      write_csr(CSR_OFFSET_REAL, ore);
      write_csr(CSR_OFFSET_IMAG, oim);
      csr_valid <= 1'b0;
      sb.settings++;
   endtask

   // uniform in [-mag, mag], two's complement
   function automatic logic [31:0] rand_around_zero(input int unsigned mag);
      return $urandom_range(0, 2 * mag) - mag;
   endfunction

   initial begin
      int unsigned kind;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset view: c = 0, step 2^-10, so the whole frame sits inside the
      // unit disk and every pixel runs to the 256 iteration default.
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd511, 10'd513);
      drain();

      // Classic view spanning +-2 with c = -0.8 + 0.156i: corners escape on
      // the very first iteration, the center runs for a while.
      apply_view(-32'sd214748365, 32'sd41875931, 32'd64, 32'd1 << 20, 32'd1 << 20,
                 32'd0, 32'd0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd600, 10'd540);
      send_pixel(10'd300, 10'd700);
      drain();

      // Saturation: largest step and offsets push z0 to the rails, c at the
      // extremes; step data with bit 31 set must be masked off.
      apply_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd1023);
      drain();

      // Zero iteration limit: no iteration at all, count 0, not escaped.
      apply_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0,
                 32'h8000_0000, 32'h7FFF_FFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd5, 10'd9);
      drain();

      // Full iteration cap with a bounded orbit: the slowest pixels there are.
      apply_view(32'd0, 32'd0, 32'd1023, 32'd1 << 18, 32'd1 << 18, 32'd0, 32'd0);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd1023, 10'd0);
      drain();

      // Random views. Most are sensible zoom/pan/c settings with short limits
      // so escapes land all over the range; the rest are raw noise.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         kind = $urandom_range(0, 3);
         if (kind != 3) begin
            apply_view(rand_around_zero(Q_ONE), rand_around_zero(Q_ONE),
                       ($urandom & 32'hFFFF_FC00) | $urandom_range(1, 48),
                       ($urandom & 32'h8000_0000) | $urandom_range(1 << 18, 1 << 21),
                       ($urandom & 32'h8000_0000) | $urandom_range(1 << 18, 1 << 21),
                       rand_around_zero(Q_ONE / 2), rand_around_zero(Q_ONE / 2));
         end else begin
            apply_view($urandom, $urandom,
                       ($urandom & 32'hFFFF_FC00) | $urandom_range(0, 63),
                       $urandom, $urandom, $urandom, $urandom);
         end

         // phase 2: flood the pixel side while results are held off, so the
         // start point queue fills and req_tready drops
         // phase 5: no idling on either side
         req_gap_max = 5;
         rsp_stall_max = 5;
         if (p == 2) begin
            req_gap_max = 0;
            hold_armed = 1'b1;
         end else if (p == 5) begin
            req_gap_max = 0;
            rsp_stall_max = 0;
         end

         for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
            send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
         end
         drain();
      end

      // Quiet tail: a stray word in this window shows up as unexpected.
      repeat (2 * DEF_ITER_CAP + 8) @(posedge clock);

      $display("covered %0d pixels over %0d register views: %0d escaped, %0d hit the limit",
               sb.pixels, sb.settings + 1, sb.escapes, sb.results - sb.escapes);
      $display("result side held off %0d time(s) for %0d cycles under a flooded pixel side",
               holds_done, HOLD_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/jet_pkg.sv
src/jet_front.sv
src/jet_queue.sv
src/jet_core.sv
src/julia_escape_time.sv
dv/tb_julia_escape_time.sv
